// ----- sv/nmd_pkg.sv -----
`default_nettype none
package nmd_pkg;

  localparam int MIN_W  = 21;  // minutes x 10^4, digits up to fifteen
  localparam int X5_W   = 23;  // five times that
  localparam int Q_W    = 22;  // floor(5M / 3)
  localparam int FRAC_W = 20;  // fraction of a degree x 10^6, below 10^6
  localparam int RECIP_W = 24;
  localparam int RECIP_SHIFT = 25;
  localparam int PROD_W = X5_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP3      = 24'd11184811;  // ceil(2^25 / 3)
  localparam logic [Q_W-1:0]     ONE_MILLION = 22'd1000000;
  localparam logic [Q_W-1:0]     TWO_MILLION = 22'd2000000;
  localparam logic [FRAC_W-1:0]  LEAD_WEIGHT = 20'd100000;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_S     = 8'h53;
  localparam logic [7:0] ASCII_W     = 8'h57;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic       kind;
    logic [7:0] quadrant;
    logic [7:0] deg_first;
    logic [7:0] deg_second;
    logic [7:0] deg_third;
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [3:0] frac_one;
    logic [3:0] frac_two;
    logic [3:0] frac_three;
    logic [3:0] frac_four;
  } nmd_coord_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } nmd_char_t;

  typedef struct packed {
    logic       neg;
    logic       kind;
    logic [7:0] deg_first;
    logic [7:0] deg_second;
    logic [7:0] deg_third;
  } nmd_meta_t;

  typedef struct packed {
    nmd_meta_t         meta;
    logic [FRAC_W-1:0] frac;
  } nmd_link_t;

  // Leading decimal digit of a value below 10^6; thresholds compare in parallel.
  function automatic logic [3:0] lead_digit(input logic [FRAC_W-1:0] r);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= FRAC_W'(k * 100000)) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- sv/nmd_if.sv -----
`default_nettype none
interface nmd_coord_if import nmd_pkg::*; ();
  logic       valid;
  logic       ready;
  nmd_coord_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nmd_char_if import nmd_pkg::*; ();
  logic      valid;
  logic      ready;
  nmd_char_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/nmd_arith.sv -----
`default_nettype none
module nmd_arith import nmd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  nmd_coord_if.sink coord,
  output logic      link_valid,
  input  logic      link_ready,
  output nmd_link_t link
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  nmd_coord_t     c1;
  nmd_meta_t      meta2, meta3;
  logic [X5_W-1:0] x5;
  logic [Q_W-1:0]  q3;

  logic [MIN_W-1:0]  minutes;
  logic [X5_W-1:0]   x5_next;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q3_next;
  nmd_meta_t         meta2_next;

  // Each stage advances when it is empty or its successor moves.
  assign en3 = !v3 || link_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign coord.ready = en1;

  always_comb begin
    minutes = MIN_W'(c1.min_tens)   * MIN_W'(100000)
            + MIN_W'(c1.min_ones)   * MIN_W'(10000)
            + MIN_W'(c1.frac_one)   * MIN_W'(1000)
            + MIN_W'(c1.frac_two)   * MIN_W'(100)
            + MIN_W'(c1.frac_three) * MIN_W'(10)
            + MIN_W'(c1.frac_four);
    // M * 100 / 60 = 5M / 3
    x5_next = {minutes, 2'b00} + X5_W'(minutes);
    meta2_next.neg        = (c1.quadrant == ASCII_S) || (c1.quadrant == ASCII_W);
    meta2_next.kind       = c1.kind;
    meta2_next.deg_first  = c1.deg_first;
    meta2_next.deg_second = c1.deg_second;
    meta2_next.deg_third  = c1.deg_third;
  end

  always_comb begin
    prod    = PROD_W'(x5) * PROD_W'(RECIP3);
    q3_next = prod[RECIP_SHIFT +: Q_W];
  end

  // Keep the low six decimal digits; the quotient stays below three million.
  always_comb begin
    link.meta = meta3;
    if (q3 >= TWO_MILLION) begin
      link.frac = FRAC_W'(q3 - TWO_MILLION);
    end else if (q3 >= ONE_MILLION) begin
      link.frac = FRAC_W'(q3 - ONE_MILLION);
    end else begin
      link.frac = FRAC_W'(q3);
    end
  end

  assign link_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= coord.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) c1 <= coord.data;
    if (en2) begin
      meta2 <= meta2_next;
      x5    <= x5_next;
    end
    if (en3) begin
      meta3 <= meta2;
      q3    <= q3_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/nmd_serial.sv -----
`default_nettype none
module nmd_serial import nmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       link_valid,
  output logic       link_ready,
  input  nmd_link_t  link,
  nmd_char_if.source chars
);

  localparam logic [3:0] POS_SIGN   = 4'd0;
  localparam logic [3:0] POS_DEG0   = 4'd1;
  localparam logic [3:0] POS_DEG1   = 4'd2;
  localparam logic [3:0] POS_DEG2   = 4'd3;
  localparam logic [3:0] POS_DOT    = 4'd4;
  localparam logic [3:0] POS_FRAC0  = 4'd5;
  localparam logic [3:0] POS_FRAC5  = 4'd10;

  logic              busy;
  logic [3:0]        pos;
  nmd_meta_t         meta;
  logic [FRAC_W-1:0] rem;

  logic              busy_next;
  logic [3:0]        pos_next;
  logic [FRAC_W-1:0] rem_next;
  logic [3:0]        digit;
  logic [FRAC_W-1:0] low;
  logic              xfer;
  logic              last;
  logic              load;

  assign digit = lead_digit(rem);
  assign low   = rem - FRAC_W'(digit) * LEAD_WEIGHT;
  assign last  = (pos == POS_FRAC5);
  assign xfer  = busy && chars.ready;

  // Take the next coordinate as the last character of this one goes out.
  assign link_ready = !busy || (xfer && last);
  assign load       = link_valid && link_ready;

  assign chars.valid          = busy;
  assign chars.data.last_char = last;

  always_comb begin
    case (pos)
      POS_SIGN: chars.data.out_char = ASCII_MINUS;
      POS_DEG0: chars.data.out_char = meta.deg_first;
      POS_DEG1: chars.data.out_char = meta.deg_second;
      POS_DEG2: chars.data.out_char = meta.deg_third;
      POS_DOT:  chars.data.out_char = ASCII_DOT;
      default:  chars.data.out_char = ASCII_ZERO + 8'(digit);
    endcase
  end

  always_comb begin
    busy_next = busy;
    pos_next  = pos;
    rem_next  = rem;
    if (load) begin
      busy_next = 1'b1;
      pos_next  = link.meta.neg ? POS_SIGN : POS_DEG0;
      rem_next  = link.frac;
    end else if (xfer) begin
      if (last) begin
        busy_next = 1'b0;
      end else begin
        // Latitude skips the third degree character.
        if (pos == POS_DEG1 && !meta.kind) begin
          pos_next = POS_DOT;
        end else begin
          pos_next = pos + 4'd1;
        end
        if (pos >= POS_FRAC0) begin
          rem_next = {low[FRAC_W-4:0], 3'b000} + {low[FRAC_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_SIGN;
    end else begin
      busy <= busy_next;
      pos  <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    if (load) meta <= link.meta;
  end

endmodule
`default_nettype wire

// ----- sv/nmea_minutes_to_decimal_degrees.sv -----
// A coordinate is registered in c1, x5 and q3 in turn, then loaded into the serializer.
// Throughput: one character per cycle while chars.ready holds; a coordinate is 9 to 11
//   characters (latitude or longitude, plus one for a minus sign), set by the serializer.
// A three-stage arithmetic pipeline takes new coordinates while characters go out.
// Reset clears all valid flags and the serializer; no item survives it.
`default_nettype none
module nmea_minutes_to_decimal_degrees import nmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  nmd_coord_if.sink  coord,
  nmd_char_if.source chars
);

  logic      link_valid;
  logic      link_ready;
  nmd_link_t link;

  nmd_arith u_arith (
    .clk        (clk),
    .rst        (rst),
    .coord      (coord),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .link       (link)
  );

  nmd_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .link       (link),
    .chars      (chars)
  );

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    link_valid |-> link.frac < FRAC_W'(1000000))
    else $error("fraction out of six-digit range");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.data.last_char |->
      chars.data.out_char >= ASCII_ZERO && chars.data.out_char <= ASCII_ZERO + 8'd9)
    else $error("final character is not a decimal digit");

  a_link_hold: assert property (@(posedge clk) disable iff (rst)
    link_valid && !link_ready |=> link_valid && $stable(link))
    else $error("pipeline output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !chars.valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
